FILE: src/gpio_register_block_with_irq_detect_top_assert.svh
// Assertion macros used by the register file of the GPIO register block.
`ifndef GPIO_REGISTER_BLOCK_WITH_IRQ_DETECT_TOP_ASSERT_SVH
`define GPIO_REGISTER_BLOCK_WITH_IRQ_DETECT_TOP_ASSERT_SVH

// Check an implication on the rising clock edge, off while reset is held.
`define GPIO_RB_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

// Check a plain condition on every rising clock edge, off while reset is held.
`define GPIO_RB_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

FILE: src/gpio_rb_pkg.sv
// Types and constants of the GPIO register block.
package gpio_rb_pkg;

    localparam int DATA_W     = 32;
    localparam int OFF_W      = 12;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 40;

    localparam logic [OFF_W-1:0] OFF_DIR  = 12'h000;
    localparam logic [OFF_W-1:0] OFF_OUT  = 12'h004;
    localparam logic [OFF_W-1:0] OFF_PINS = 12'h008;
    localparam logic [OFF_W-1:0] OFF_IE   = 12'h00C;
    localparam logic [OFF_W-1:0] OFF_IS   = 12'h010;
    localparam logic [OFF_W-1:0] OFF_TRIG = 12'h014;
    localparam logic [OFF_W-1:0] OFF_POL  = 12'h018;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [OFF_W-1:0]  offset;
        logic [DATA_W-1:0] wdata;
    } access_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              irq_line;
    } access_rsp_t;

endpackage

FILE: src/gpio_rb_detect.sv
// Per-pin edge and level interrupt detection on an output register write.
module gpio_rb_detect #(
    parameter int PIN_COUNT = 32
) (
    input  logic [PIN_COUNT-1:0] prev_out,
    input  logic [PIN_COUNT-1:0] next_out,
    input  logic [PIN_COUNT-1:0] polarity,
    input  logic [PIN_COUNT-1:0] trigger_mode,
    input  logic [PIN_COUNT-1:0] irq_enable,
    input  logic [PIN_COUNT-1:0] status_in,
    output logic [PIN_COUNT-1:0] status_out
);

    logic [PIN_COUNT-1:0] rise;
    logic [PIN_COUNT-1:0] fall;
    logic [PIN_COUNT-1:0] edge_hit;
    logic [PIN_COUNT-1:0] level_hit;
    logic [PIN_COUNT-1:0] edge_pins;
    logic [PIN_COUNT-1:0] level_pins;
    logic [PIN_COUNT-1:0] edge_status;

    always_comb begin
        rise        = ~prev_out & next_out;
        fall        = prev_out & ~next_out;
        edge_hit    = (polarity & rise) | (~polarity & fall);
        level_hit   = ~(polarity ^ next_out);
        edge_pins   = irq_enable & ~trigger_mode;
        level_pins  = irq_enable & trigger_mode;
        edge_status = status_in | (edge_hit & edge_pins);
        status_out  = (edge_status & ~level_pins) | (level_hit & level_pins);
    end

endmodule

FILE: src/gpio_rb_regs.sv
// Register file, read mux and interrupt line of the GPIO register block.
`include "gpio_register_block_with_irq_detect_top_assert.svh"

module gpio_rb_regs #(
    parameter int PIN_COUNT = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  gpio_rb_pkg::access_req_t req,
    output gpio_rb_pkg::access_rsp_t rsp
);

    logic [PIN_COUNT-1:0] dir_reg, dir_next;
    logic [PIN_COUNT-1:0] out_reg, out_next;
    logic [PIN_COUNT-1:0] ie_reg, ie_next;
    logic [PIN_COUNT-1:0] is_reg, is_next;
    logic [PIN_COUNT-1:0] trig_reg, trig_next;
    logic [PIN_COUNT-1:0] pol_reg, pol_next;
    logic [PIN_COUNT-1:0] wdata_pins;
    logic [PIN_COUNT-1:0] det_status;
    logic [PIN_COUNT-1:0] read_pins;

    assign wdata_pins = req.wdata[PIN_COUNT-1:0];

    gpio_rb_detect #(
        .PIN_COUNT(PIN_COUNT)
    ) u_detect (
        .prev_out    (out_reg),
        .next_out    (wdata_pins),
        .polarity    (pol_reg),
        .trigger_mode(trig_reg),
        .irq_enable  (ie_reg),
        .status_in   (is_reg),
        .status_out  (det_status)
    );

    always_comb begin
        dir_next  = dir_reg;
        out_next  = out_reg;
        ie_next   = ie_reg;
        is_next   = is_reg;
        trig_next = trig_reg;
        pol_next  = pol_reg;
        if (fire && req.req_type == gpio_rb_pkg::REQ_WRITE) begin
            case (req.offset)
                gpio_rb_pkg::OFF_DIR: begin
                    dir_next = wdata_pins;
                end
                gpio_rb_pkg::OFF_OUT: begin
                    out_next = wdata_pins;
                    is_next  = det_status;
                end
                gpio_rb_pkg::OFF_IE: begin
                    ie_next = wdata_pins;
                end
                gpio_rb_pkg::OFF_IS: begin
                    is_next = is_reg & ~wdata_pins;
                end
                gpio_rb_pkg::OFF_TRIG: begin
                    trig_next = wdata_pins;
                end
                gpio_rb_pkg::OFF_POL: begin
                    pol_next = wdata_pins;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        read_pins = '0;
        if (req.req_type == gpio_rb_pkg::REQ_READ) begin
            case (req.offset)
                gpio_rb_pkg::OFF_DIR:  read_pins = dir_reg;
                gpio_rb_pkg::OFF_OUT:  read_pins = out_reg;
                gpio_rb_pkg::OFF_PINS: read_pins = out_reg & dir_reg;
                gpio_rb_pkg::OFF_IE:   read_pins = ie_reg;
                gpio_rb_pkg::OFF_IS:   read_pins = is_reg;
                gpio_rb_pkg::OFF_TRIG: read_pins = trig_reg;
                gpio_rb_pkg::OFF_POL:  read_pins = pol_reg;
                default:               read_pins = '0;
            endcase
        end
        rsp.rdata    = gpio_rb_pkg::DATA_W'(read_pins);
        rsp.irq_line = |(is_next & ie_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg  <= '0;
            out_reg  <= '0;
            ie_reg   <= '0;
            is_reg   <= '0;
            trig_reg <= '0;
            pol_reg  <= '0;
        end else begin
            dir_reg  <= dir_next;
            out_reg  <= out_next;
            ie_reg   <= ie_next;
            is_reg   <= is_next;
            trig_reg <= trig_next;
            pol_reg  <= pol_next;
        end
    end

    `GPIO_RB_ASSERT_IMPL(a_dir_write, aclk, aresetn,
        fire && req.req_type == gpio_rb_pkg::REQ_WRITE && req.offset == gpio_rb_pkg::OFF_DIR,
        dir_reg == $past(wdata_pins), "direction write not stored")
    `GPIO_RB_ASSERT_IMPL(a_disabled_hold, aclk, aresetn,
        fire && req.req_type == gpio_rb_pkg::REQ_WRITE && req.offset == gpio_rb_pkg::OFF_OUT,
        (is_reg & ~ie_reg) == $past(is_reg & ~ie_reg), "disabled pin status changed")
    `GPIO_RB_ASSERT_IMPL(a_status_clear, aclk, aresetn,
        fire && req.req_type == gpio_rb_pkg::REQ_WRITE && req.offset == gpio_rb_pkg::OFF_IS,
        (is_reg & $past(wdata_pins)) == '0, "status bits not cleared")
    `GPIO_RB_ASSERT_IMPL(a_pins_ro, aclk, aresetn,
        fire && req.req_type == gpio_rb_pkg::REQ_WRITE && req.offset == gpio_rb_pkg::OFF_PINS,
        $stable(out_reg) && $stable(dir_reg) && $stable(is_reg), "pin value write took effect")

endmodule

FILE: src/gpio_register_block_with_irq_detect_top.sv
// Top level of the GPIO register block with edge and level interrupt detection.
//
//   channel  dir  tdata (low bit up)            tuser
//   s_       in   offset[11:0], wdata[43:12]    req_type
//   m_       out  rdata[31:0], irq_line[32]     -
//
// One request per cycle sustained while m_tready does not stall the result.
// The request sits in an input register, then one pass of decode, detection
// and read mux updates the registers and loads the result register.
// A stalled result holds; s_tready stays high while the input register can move.
// Synchronous active-low reset clears the GPIO registers and both valid flags.
module gpio_register_block_with_irq_detect_top #(
    parameter int PIN_COUNT = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gpio_rb_pkg::S_TDATA_W-1:0] s_tdata,  // offset, wdata
    input  logic                              s_tuser,  // req_type
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [gpio_rb_pkg::M_TDATA_W-1:0] m_tdata   // rdata, irq_line
);

    logic                        in_valid_reg;
    gpio_rb_pkg::access_req_t    in_req_reg;
    logic                        out_valid_reg;
    gpio_rb_pkg::access_rsp_t    out_rsp_reg;
    gpio_rb_pkg::access_rsp_t    rsp;
    logic                        advance;
    logic                        load;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    gpio_rb_regs #(
        .PIN_COUNT(PIN_COUNT)
    ) u_regs (
        .aclk   (aclk),
        .aresetn(aresetn),
        .fire   (advance),
        .req    (in_req_reg),
        .rsp    (rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            in_req_reg.req_type <= s_tuser;
            in_req_reg.offset   <= s_tdata[gpio_rb_pkg::OFF_W-1:0];
            in_req_reg.wdata    <= s_tdata[gpio_rb_pkg::OFF_W +: gpio_rb_pkg::DATA_W];
        end
        if (advance) begin
            out_rsp_reg <= rsp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(gpio_rb_pkg::M_TDATA_W - gpio_rb_pkg::DATA_W - 1){1'b0}},
                       out_rsp_reg.irq_line, out_rsp_reg.rdata};

endmodule
